@@ rtl/txchk_pkg.sv @@
package txchk_pkg;

  localparam int COUNT_WIDTH_DEF = 32;

  localparam int Q_DEPTH = 3;
  localparam int Q_CNT_W = 2;

  localparam logic [3:0] KIND_TRAIL   = 4'd0;
  localparam logic [3:0] KIND_BELL    = 4'd1;
  localparam logic [3:0] KIND_BS      = 4'd2;
  localparam logic [3:0] KIND_FF      = 4'd3;
  localparam logic [3:0] KIND_CR      = 4'd4;
  localparam logic [3:0] KIND_VT      = 4'd5;
  localparam logic [3:0] KIND_DEL     = 4'd6;
  localparam logic [3:0] KIND_ODD     = 4'd7;
  localparam logic [3:0] KIND_HIGH    = 4'd8;
  localparam logic [3:0] KIND_UNTERM  = 4'd9;
  localparam logic [3:0] KIND_SUMMARY = 4'd10;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_DEL = 8'h7F;

  localparam logic MODE_DATA = 1'b0;
  localparam logic MODE_EOS  = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] line_number;
    logic [7:0]  char_code;
    logic [31:0] total_chars;
    logic [31:0] newline_total;
    logic [31:0] space_total;
    logic [31:0] tab_total;
    logic [31:0] bad_control_total;
    logic [31:0] non_ascii_total;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic a_vld;
    logic b_vld;
  } push_ctl_t;

endpackage

@@ rtl/txchk_res_q.sv @@
module txchk_res_q (
  input  logic                  clk,
  input  logic                  rst_n,
  input  txchk_pkg::push_ctl_t  push,
  input  txchk_pkg::out_item_t  push_a,
  input  txchk_pkg::out_item_t  push_b,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_stall,
  output txchk_pkg::out_item_t  out_data
);

  logic [txchk_pkg::Q_CNT_W-1:0] count_r, count_nxt, base;
  txchk_pkg::out_item_t          q_r   [txchk_pkg::Q_DEPTH];
  txchk_pkg::out_item_t          q_nxt [txchk_pkg::Q_DEPTH];
  logic                          pop;

  assign out_valid = (count_r != '0);
  assign out_data  = q_r[0];
  assign pop       = out_valid && !out_stall;
  assign base      = count_r - txchk_pkg::Q_CNT_W'(pop);
  // room for two pushes only while at most one entry is held
  assign full      = (count_r > txchk_pkg::Q_CNT_W'(1));

  always_comb begin
    for (int i = 0; i < txchk_pkg::Q_DEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (pop) begin
      for (int i = 0; i < txchk_pkg::Q_DEPTH - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
    end
    for (int i = 0; i < txchk_pkg::Q_DEPTH; i++) begin
      if (push.a_vld && base == txchk_pkg::Q_CNT_W'(i)) begin
        q_nxt[i] = push_a;
      end
      if (push.b_vld && (base + txchk_pkg::Q_CNT_W'(1)) == txchk_pkg::Q_CNT_W'(i)) begin
        q_nxt[i] = push_b;
      end
    end
    count_nxt = base + txchk_pkg::Q_CNT_W'(push.a_vld) + txchk_pkg::Q_CNT_W'(push.b_vld);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  a_b_needs_a: assert property (@(posedge clk) disable iff (!rst_n)
    push.b_vld |-> push.a_vld)
    else $error("second push without first");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.a_vld |-> count_r <= txchk_pkg::Q_CNT_W'(1))
    else $error("push into full queue");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push.a_vld) |=> count_r == $past(count_r) - txchk_pkg::Q_CNT_W'(1))
    else $error("queue count lost track on pop");

endmodule

@@ rtl/text_byte_stream_checker.sv @@
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid / in_stall | txchk_pkg::in_item_t  (mode, data_byte)
// out_    | output    | out_valid/out_stall | txchk_pkg::out_item_t (finding or summary)
//
// One byte per cycle while in_stall is low: classification and counter updates
// sit in front of a three-entry result queue, the only register on the result path.
// An end-of-stream transaction with an open last line pushes two results;
// in_stall comes from the queue fill count only. Reset is synchronous, active-low:
// it clears all counters and trail_r, sets closed_r, and needs no clearing pass.
// A stalled output keeps up to three results; input stalls once two are held.
module text_byte_stream_checker #(
  parameter int COUNT_WIDTH = txchk_pkg::COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  txchk_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output txchk_pkg::out_item_t out_data
);

  logic [COUNT_WIDTH-1:0] nl_cnt_r, byte_cnt_r, sp_cnt_r, tab_cnt_r, bad_cnt_r, high_cnt_r;
  logic [COUNT_WIDTH-1:0] nl_cnt_nxt, byte_cnt_nxt, sp_cnt_nxt, tab_cnt_nxt, bad_cnt_nxt;
  logic [COUNT_WIDTH-1:0] high_cnt_nxt;
  logic                   trail_r, trail_nxt, closed_r, closed_nxt;

  logic                 accept, q_full;
  logic [7:0]           c;
  logic                 is_nl, is_sp, is_tab, is_bad, is_high;
  logic                 find_vld;
  logic [3:0]           find_kind;
  logic [31:0]          line_now, line_trail;
  txchk_pkg::push_ctl_t push;
  txchk_pkg::out_item_t push_a, push_b, summary;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

  function automatic logic [31:0] clamp32(input logic [COUNT_WIDTH:0] v);
    logic [64:0] w;
    w = 65'(v);
    return (w > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign c        = in_data.data_byte;

  assign is_nl   = (c == txchk_pkg::CH_NL);
  assign is_sp   = (c == txchk_pkg::CH_SP);
  assign is_tab  = (c == txchk_pkg::CH_TAB);
  assign is_bad  = ((c < txchk_pkg::CH_SP) && !is_tab && !is_nl) || (c == txchk_pkg::CH_DEL);
  assign is_high = c[7];

  assign line_now   = clamp32({1'b0, nl_cnt_r} + (COUNT_WIDTH+1)'(1));
  assign line_trail = clamp32({1'b0, sat_inc(nl_cnt_r)});

  always_comb begin
    find_vld  = 1'b1;
    find_kind = txchk_pkg::KIND_ODD;
    if (is_nl) begin
      find_vld  = trail_r;
      find_kind = txchk_pkg::KIND_TRAIL;
    end else begin
      case (c)
        txchk_pkg::CH_BEL: find_kind = txchk_pkg::KIND_BELL;
        txchk_pkg::CH_BS:  find_kind = txchk_pkg::KIND_BS;
        txchk_pkg::CH_FF:  find_kind = txchk_pkg::KIND_FF;
        txchk_pkg::CH_CR:  find_kind = txchk_pkg::KIND_CR;
        txchk_pkg::CH_VT:  find_kind = txchk_pkg::KIND_VT;
        txchk_pkg::CH_DEL: find_kind = txchk_pkg::KIND_DEL;
        default: begin
          if (c < txchk_pkg::CH_SP && !is_tab) begin
            find_kind = txchk_pkg::KIND_ODD;
          end else if (is_high) begin
            find_kind = txchk_pkg::KIND_HIGH;
          end else begin
            find_vld = 1'b0;
          end
        end
      endcase
    end
  end

  always_comb begin
    summary                   = '0;
    summary.kind              = txchk_pkg::KIND_SUMMARY;
    summary.line_number       = line_now;
    summary.total_chars       = clamp32({1'b0, byte_cnt_r});
    summary.newline_total     = clamp32({1'b0, nl_cnt_r});
    summary.space_total       = clamp32({1'b0, sp_cnt_r});
    summary.tab_total         = clamp32({1'b0, tab_cnt_r});
    summary.bad_control_total = clamp32({1'b0, bad_cnt_r});
    summary.non_ascii_total   = clamp32({1'b0, high_cnt_r});
    summary.last              = 1'b1;

    push   = '0;
    push_a = '0;
    push_b = summary;

    nl_cnt_nxt   = nl_cnt_r;
    byte_cnt_nxt = byte_cnt_r;
    sp_cnt_nxt   = sp_cnt_r;
    tab_cnt_nxt  = tab_cnt_r;
    bad_cnt_nxt  = bad_cnt_r;
    high_cnt_nxt = high_cnt_r;
    trail_nxt    = trail_r;
    closed_nxt   = closed_r;

    if (accept) begin
      if (in_data.mode == txchk_pkg::MODE_EOS) begin
        if (!closed_r) begin
          push_a.kind        = txchk_pkg::KIND_UNTERM;
          push_a.line_number = line_now;
          push.a_vld         = 1'b1;
          push.b_vld         = 1'b1;
        end else begin
          push_a     = summary;
          push.a_vld = 1'b1;
        end
        nl_cnt_nxt   = '0;
        byte_cnt_nxt = '0;
        sp_cnt_nxt   = '0;
        tab_cnt_nxt  = '0;
        bad_cnt_nxt  = '0;
        high_cnt_nxt = '0;
        trail_nxt    = 1'b0;
        closed_nxt   = 1'b1;
      end else begin
        byte_cnt_nxt = sat_inc(byte_cnt_r);
        if (is_nl)   nl_cnt_nxt   = sat_inc(nl_cnt_r);
        if (is_sp)   sp_cnt_nxt   = sat_inc(sp_cnt_r);
        if (is_tab)  tab_cnt_nxt  = sat_inc(tab_cnt_r);
        if (is_bad)  bad_cnt_nxt  = sat_inc(bad_cnt_r);
        if (is_high) high_cnt_nxt = sat_inc(high_cnt_r);
        trail_nxt  = is_sp || is_tab;
        closed_nxt = is_nl;
        push_a.kind        = find_kind;
        push_a.line_number = is_nl ? line_trail : line_now;
        push_a.char_code   = c;
        push_a.last        = 1'b1;
        push.a_vld         = find_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nl_cnt_r   <= '0;
      byte_cnt_r <= '0;
      sp_cnt_r   <= '0;
      tab_cnt_r  <= '0;
      bad_cnt_r  <= '0;
      high_cnt_r <= '0;
      trail_r    <= 1'b0;
      closed_r   <= 1'b1;
    end else begin
      nl_cnt_r   <= nl_cnt_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      sp_cnt_r   <= sp_cnt_nxt;
      tab_cnt_r  <= tab_cnt_nxt;
      bad_cnt_r  <= bad_cnt_nxt;
      high_cnt_r <= high_cnt_nxt;
      trail_r    <= trail_nxt;
      closed_r   <= closed_nxt;
    end
  end

  txchk_res_q u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_a    (push_a),
    .push_b    (push_b),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.mode == txchk_pkg::MODE_EOS)
      |=> (byte_cnt_r == '0 && nl_cnt_r == '0 && closed_r && !trail_r))
    else $error("state not cleared after end of stream");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == txchk_pkg::KIND_SUMMARY) |-> out_data.last)
    else $error("summary without last");

  a_unterm_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == txchk_pkg::KIND_UNTERM) |-> !out_data.last)
    else $error("unterminated finding marked last");

endmodule
